@@ rtl/iase_pkg.sv @@
// Shared types, constants and arithmetic helpers for the infix add/sub evaluator.
package iase_pkg;

  localparam int VALUE_W          = 32;
  localparam int IASE_MAX_NESTING = 16;
  localparam int IASE_QUEUE_DEPTH = 4;

  localparam logic [VALUE_W-1:0] VALUE_SIGN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_TOO_DEEP  = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_OTHER = 3'd0,
    K_DIGIT = 3'd1,
    K_SIGN  = 3'd2,
    K_OPEN  = 3'd3,
    K_CLOSE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_MAIN = 3'b001,
    PH_POP  = 3'b010,
    PH_EMIT = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
  } out_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       neg;
    logic       last;
  } op_t;

  // returns {overflow, a + (neg ? -x : x)}
  function automatic logic [VALUE_W:0] add_signed(logic [VALUE_W-1:0] a,
                                                   logic [VALUE_W-1:0] x,
                                                   logic neg);
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] r;
    logic [VALUE_W-1:0] t;
    logic               ov;
    b  = neg ? (~x + {{(VALUE_W-1){1'b0}}, 1'b1}) : x;
    r  = a + b;
    t  = (a ^ r) & (b ^ r);
    ov = (neg && (x == VALUE_SIGN)) || t[VALUE_W-1];
    return {ov, r};
  endfunction

  // returns {overflow, p * 10 + d}
  function automatic logic [VALUE_W:0] mul10_add(logic [VALUE_W-1:0] p, logic [3:0] d);
    logic [VALUE_W+3:0] t;
    logic               ov;
    t  = ({4'b0, p} << 3) + ({4'b0, p} << 1) + {{VALUE_W{1'b0}}, d};
    ov = |t[VALUE_W+3:VALUE_W-1];
    return {ov, t[VALUE_W-1:0]};
  endfunction

endpackage

@@ rtl/iase_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module iase_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/iase_front.sv @@
// Front stage: accepts characters and classifies them into execution ops.
module iase_front import iase_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     op_valid,
  input  logic     op_ready,
  output op_t      op
);

  logic valid_r, valid_nxt;
  op_t  op_r, op_nxt;
  op_t  cls;

  always_comb begin
    cls.kind  = K_OTHER;
    cls.digit = 4'(in_data.char_code - CH_ZERO);
    cls.neg   = (in_data.char_code == CH_MINUS);
    cls.last  = in_data.last_char;
    if (in_data.char_code inside {[CH_ZERO:CH_NINE]}) begin
      cls.kind = K_DIGIT;
    end else if (in_data.char_code inside {CH_PLUS, CH_MINUS}) begin
      cls.kind = K_SIGN;
    end else if (in_data.char_code == CH_OPEN) begin
      cls.kind = K_OPEN;
    end else if (in_data.char_code == CH_CLOSE) begin
      cls.kind = K_CLOSE;
    end
  end

  assign in_stall = valid_r && !op_ready;

  always_comb begin
    valid_nxt = valid_r;
    op_nxt    = op_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      op_nxt    = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    op_r <= op_nxt;
  end

  assign op_valid = valid_r;
  assign op       = op_r;

endmodule

@@ rtl/iase_queue.sv @@
// Short op queue between the front stage and the execution unit.
module iase_queue import iase_pkg::*; #(
  parameter int DEPTH = IASE_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic head_valid,
  output op_t  head_op,
  input  logic pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  op_t           entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ rtl/iase_back.sv @@
// Execution unit: running total, pending number, paren stack and result register.
module iase_back import iase_pkg::*; #(
  parameter int MAX_NESTING = IASE_MAX_NESTING
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  input  op_t       op,
  output logic      op_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int LW = $clog2(MAX_NESTING + 1);
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int SW = VALUE_W + 1;

  logic [VALUE_W-1:0] total_r, total_nxt;
  logic [VALUE_W-1:0] pend_r, pend_nxt;
  logic               neg_r, neg_nxt;
  logic [LW-1:0]      level_r, level_nxt;
  logic [1:0]         sticky_r, sticky_nxt;
  phase_t             phase_r, phase_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [SW-1:0]      ram_wdata, ram_rdata;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [LW-1:0]      level_dec;
  logic [VALUE_W:0]   fold_res, pop_res, dig_res;
  logic [1:0]         code;
  logic               out_free;

  assign level_dec = level_r - LW'(1);
  assign ram_raddr = level_dec[AW-1:0];
  assign ram_waddr = level_r[AW-1:0];
  assign ram_wdata = {total_r, neg_r};

  iase_ram #(.WIDTH(SW), .DEPTH(MAX_NESTING), .AW(AW)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fold_res = add_signed(total_r, pend_r, neg_r);
  assign pop_res  = add_signed(ram_rdata[SW-1:1], total_r, ram_rdata[0]);
  assign dig_res  = mul10_add(pend_r, op.digit);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    total_nxt     = total_r;
    pend_nxt      = pend_r;
    neg_nxt       = neg_r;
    level_nxt     = level_r;
    sticky_nxt    = sticky_r;
    phase_nxt     = phase_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    op_pop        = 1'b0;
    code          = ST_OK;
    if (op_valid) begin
      case (phase_r)
        PH_MAIN: begin
          case (op.kind)
            K_DIGIT: begin
              pend_nxt = dig_res[VALUE_W-1:0];
              if (dig_res[VALUE_W]) code = ST_OVERFLOW;
            end
            K_SIGN, K_CLOSE: begin
              total_nxt = fold_res[VALUE_W-1:0];
              pend_nxt  = '0;
              if (fold_res[VALUE_W]) code = ST_OVERFLOW;
              if (op.kind == K_SIGN) neg_nxt = op.neg;
            end
            K_OPEN: begin
              if (level_r < LW'(MAX_NESTING)) begin
                ram_we    = 1'b1;
                level_nxt = level_r + LW'(1);
                total_nxt = '0;
                neg_nxt   = 1'b0;
              end else begin
                code = ST_TOO_DEEP;
              end
            end
            default: begin
            end
          endcase
          if (op.kind == K_CLOSE) begin
            phase_nxt = PH_POP;
          end else if (op.last) begin
            phase_nxt = PH_EMIT;
          end else begin
            op_pop = 1'b1;
          end
        end
        PH_POP: begin
          if (level_r != '0) begin
            level_nxt = level_dec;
            total_nxt = pop_res[VALUE_W-1:0];
            if (pop_res[VALUE_W]) code = ST_OVERFLOW;
          end else begin
            code = ST_UNMATCHED;
          end
          if (op.last) begin
            phase_nxt = PH_EMIT;
          end else begin
            phase_nxt = PH_MAIN;
            op_pop    = 1'b1;
          end
        end
        PH_EMIT: begin
          if (out_free) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.value  = fold_res[VALUE_W-1:0];
            out_data_nxt.status = (sticky_r != ST_OK) ? sticky_r :
                                  (fold_res[VALUE_W] ? ST_OVERFLOW : ST_OK);
            phase_nxt           = PH_MAIN;
            op_pop              = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_MAIN;
        end
      endcase
    end
    if (code != ST_OK && sticky_r == ST_OK) begin
      sticky_nxt = code;
    end
    if (op_valid && phase_r == PH_EMIT && out_free) begin
      total_nxt  = '0;
      pend_nxt   = '0;
      neg_nxt    = 1'b0;
      level_nxt  = '0;
      sticky_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      pend_r      <= '0;
      neg_r       <= 1'b0;
      level_r     <= '0;
      sticky_r    <= ST_OK;
      phase_r     <= PH_MAIN;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      neg_r       <= neg_nxt;
      level_r     <= level_nxt;
      sticky_r    <= sticky_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/infix_add_sub_evaluator.sv @@
// Infix add/subtract expression evaluator with parentheses, top level.
// One ASCII character is taken per word; digits, '+', '-', '(' and ')' act and every
// other byte is skipped. The word flagged last_char yields one result word holding the
// 32-bit wrapped value and a sticky status (first error wins), after which all state
// clears for the next expression. The execution unit handles one character per cycle
// unless an output stall holds it; a ')' adds a paren stack pop step and the final
// character adds a result fold step. A queue of QUEUE_DEPTH ops between the classifying
// front stage and the execution unit absorbs those extra steps and output stalls. The
// last character goes through the front stage register and the queue, and the result
// word is registered at the fold step, after any ops queued ahead of it or output stalls.
// The paren stack holds MAX_NESTING levels; deeper '(' are dropped and flagged.
module infix_add_sub_evaluator import iase_pkg::*; #(
  parameter int MAX_NESTING = IASE_MAX_NESTING,
  parameter int QUEUE_DEPTH = IASE_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic front_valid, queue_ready, head_valid, head_pop;
  op_t  front_op, head_op;

  iase_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .op_valid (front_valid),
    .op_ready (queue_ready),
    .op       (front_op)
  );

  iase_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .push_op    (front_op),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (head_pop)
  );

  iase_back #(.MAX_NESTING(MAX_NESTING)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (head_valid),
    .op        (head_op),
    .op_pop    (head_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
